>>> design/teq_pkg.sv
// Shared types and codes for the timer expiry queue.
// No dependencies; imported by every module of the block.
`default_nettype none

package teq_pkg;

	localparam int DEF_TIMER_SLOTS = 16;

	localparam logic [1:0] K_ADD     = 2'd0;
	localparam logic [1:0] K_CANCEL  = 2'd1;
	localparam logic [1:0] K_EXECUTE = 2'd2;
	localparam logic [1:0] K_UNUSED  = 2'd3;

	localparam logic [1:0] RK_ADD    = 2'd0;
	localparam logic [1:0] RK_CANCEL = 2'd1;
	localparam logic [1:0] RK_FIRED  = 2'd2;
	localparam logic [1:0] RK_WAIT   = 2'd3;

	localparam logic [1:0] ST_OK   = 2'd0;
	localparam logic [1:0] ST_FULL = 2'd1;
	localparam logic [1:0] ST_NONE = 2'd2;

	typedef struct packed {
		logic [63:0] expiry;
		logic [15:0] owner;
		logic [15:0] tag;
	} entry_t;

	typedef struct packed {
		logic        strobe;
		logic [1:0]  rkind;
		logic [1:0]  status;
		logic [15:0] owner;
		logic [15:0] tag;
		logic [63:0] wait_ms;
		logic        last;
	} result_t;

endpackage

`default_nettype wire

>>> design/timer_expiry_queue_top.sv
// Top level of the timer expiry queue: sequencer, circular entry memory, compare unit.
// Depends on teq_pkg and teq_out.
//
//   channel   | handshake            | payload
//   ----------+----------------------+----------------------------------------------
//   command   | start / busy         | kind, now_ms, timeout_ms, owner, timer_tag
//   result    | result_valid strobe  | result_kind, status, fired_owner, fired_tag,
//             |                      | wait_ms, last
//
// Busy while an add moves the entries behind the new one, a cancel scans or shifts
// entries down, or an execute pops fired timers; a full table answers at accept with
// busy low. The entry memory has a registered read. Results leave through a register
// and are shown in the next cycle.
// Reset empties the table at once; no clearing pass. The receiver cannot stall.
`default_nettype none

module timer_expiry_queue_top import teq_pkg::*; #(
	parameter int TIMER_SLOTS = DEF_TIMER_SLOTS
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        start,
	output logic             busy,
	input  wire logic [1:0]  kind,
	input  wire logic [63:0] now_ms,
	input  wire logic [30:0] timeout_ms,
	input  wire logic [15:0] owner,
	input  wire logic [15:0] timer_tag,
	output logic             result_valid,
	output logic [1:0]       result_kind,
	output logic [1:0]       status,
	output logic [15:0]      fired_owner,
	output logic [15:0]      fired_tag,
	output logic [63:0]      wait_ms,
	output logic             last
);

	localparam int IDX_W = $clog2(TIMER_SLOTS);
	localparam int CNT_W = $clog2(TIMER_SLOTS + 1);
	localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(TIMER_SLOTS - 1);
	localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(TIMER_SLOTS);

	typedef enum logic [8:0] {
		S_IDLE    = 9'b000000001,
		S_ADD_RD  = 9'b000000010,
		S_ADD_CMP = 9'b000000100,
		S_CAN_RD  = 9'b000001000,
		S_CAN_CMP = 9'b000010000,
		S_SH_RD   = 9'b000100000,
		S_SH_WR   = 9'b001000000,
		S_EXE_RD  = 9'b010000000,
		S_EXE_CMP = 9'b100000000
	} state_t;

	function automatic logic [IDX_W-1:0] idx_inc(input logic [IDX_W-1:0] i);
		return (i == LAST_IDX) ? '0 : IDX_W'(i + 1'b1);
	endfunction

	function automatic logic [IDX_W-1:0] idx_dec(input logic [IDX_W-1:0] i);
		return (i == '0) ? LAST_IDX : IDX_W'(i - 1'b1);
	endfunction

	state_t           state_q, state_d;
	logic [CNT_W-1:0] count_q, count_d;
	logic [CNT_W-1:0] left_q, left_d;
	logic [IDX_W-1:0] head_q, head_d;
	logic [IDX_W-1:0] cur_q, cur_d;
	logic [IDX_W-1:0] hole_q, hole_d;
	logic [63:0]      now_q, now_d;
	logic [63:0]      exp_q, exp_d;
	logic [15:0]      owner_q, owner_d;
	logic [15:0]      tag_q, tag_d;

	entry_t           mem [TIMER_SLOTS];
	entry_t           rdata_q;
	logic             rd_en;
	logic [IDX_W-1:0] rd_addr;
	logic             wr_en;
	logic [IDX_W-1:0] wr_addr;
	entry_t           wr_data;

	logic [CNT_W:0]   tail_sum;
	logic [IDX_W-1:0] tail;
	entry_t           new_entry;
	result_t          res;

	assign tail_sum  = (CNT_W + 1)'(head_q) + (CNT_W + 1)'(count_q);
	assign tail      = (tail_sum >= (CNT_W + 1)'(TIMER_SLOTS)) ?
		IDX_W'(tail_sum - (CNT_W + 1)'(TIMER_SLOTS)) : IDX_W'(tail_sum);
	assign new_entry = '{expiry: exp_q, owner: owner_q, tag: tag_q};
	assign busy      = (state_q != S_IDLE);

	always_comb begin
		state_d = state_q;
		count_d = count_q;
		left_d  = left_q;
		head_d  = head_q;
		cur_d   = cur_q;
		hole_d  = hole_q;
		now_d   = now_q;
		exp_d   = exp_q;
		owner_d = owner_q;
		tag_d   = tag_q;
		rd_en   = 1'b0;
		rd_addr = cur_q;
		wr_en   = 1'b0;
		wr_addr = hole_q;
		wr_data = new_entry;
		res     = '0;
		case (state_q)
			S_IDLE: begin
				if (start) begin
					now_d   = now_ms;
					owner_d = owner;
					tag_d   = timer_tag;
					exp_d   = now_ms + 64'(timeout_ms);
					case (kind)
						K_ADD: begin
							if (count_q == FULL_CNT) begin
								res.strobe = 1'b1;
								res.rkind  = RK_ADD;
								res.status = ST_FULL;
								res.last   = 1'b1;
							end else begin
								hole_d  = tail;
								cur_d   = idx_dec(tail);
								left_d  = count_q;
								state_d = S_ADD_RD;
							end
						end
						K_CANCEL: begin
							cur_d   = head_q;
							left_d  = count_q;
							state_d = S_CAN_RD;
						end
						K_EXECUTE: begin
							state_d = S_EXE_RD;
						end
						default: begin
						end
					endcase
				end
			end
			S_ADD_RD: begin
				if (left_q == '0) begin
					wr_en      = 1'b1;
					count_d    = CNT_W'(count_q + 1'b1);
					res.strobe = 1'b1;
					res.rkind  = RK_ADD;
					res.last   = 1'b1;
					state_d    = S_IDLE;
				end else begin
					rd_en   = 1'b1;
					state_d = S_ADD_CMP;
				end
			end
			S_ADD_CMP: begin
				wr_en = 1'b1;
				if (rdata_q.expiry > exp_q) begin
					wr_data = rdata_q;
					hole_d  = cur_q;
					cur_d   = idx_dec(cur_q);
					left_d  = CNT_W'(left_q - 1'b1);
					state_d = S_ADD_RD;
				end else begin
					count_d    = CNT_W'(count_q + 1'b1);
					res.strobe = 1'b1;
					res.rkind  = RK_ADD;
					res.last   = 1'b1;
					state_d    = S_IDLE;
				end
			end
			S_CAN_RD: begin
				if (left_q == '0) begin
					res.strobe = 1'b1;
					res.rkind  = RK_CANCEL;
					res.status = ST_NONE;
					res.last   = 1'b1;
					state_d    = S_IDLE;
				end else begin
					rd_en   = 1'b1;
					state_d = S_CAN_CMP;
				end
			end
			S_CAN_CMP: begin
				cur_d  = idx_inc(cur_q);
				left_d = CNT_W'(left_q - 1'b1);
				if (rdata_q.owner == owner_q && rdata_q.tag == tag_q) begin
					hole_d  = cur_q;
					state_d = S_SH_RD;
				end else begin
					state_d = S_CAN_RD;
				end
			end
			S_SH_RD: begin
				if (left_q == '0) begin
					count_d    = CNT_W'(count_q - 1'b1);
					res.strobe = 1'b1;
					res.rkind  = RK_CANCEL;
					res.last   = 1'b1;
					state_d    = S_IDLE;
				end else begin
					rd_en   = 1'b1;
					state_d = S_SH_WR;
				end
			end
			S_SH_WR: begin
				wr_en   = 1'b1;
				wr_data = rdata_q;
				hole_d  = cur_q;
				cur_d   = idx_inc(cur_q);
				left_d  = CNT_W'(left_q - 1'b1);
				state_d = S_SH_RD;
			end
			S_EXE_RD: begin
				if (count_q == '0) begin
					res.strobe = 1'b1;
					res.rkind  = RK_WAIT;
					res.last   = 1'b1;
					state_d    = S_IDLE;
				end else begin
					rd_en   = 1'b1;
					rd_addr = head_q;
					state_d = S_EXE_CMP;
				end
			end
			S_EXE_CMP: begin
				res.strobe = 1'b1;
				if (rdata_q.expiry <= now_q) begin
					res.rkind = RK_FIRED;
					res.owner = rdata_q.owner;
					res.tag   = rdata_q.tag;
					head_d    = idx_inc(head_q);
					count_d   = CNT_W'(count_q - 1'b1);
					state_d   = S_EXE_RD;
				end else begin
					res.rkind   = RK_WAIT;
					res.wait_ms = rdata_q.expiry - now_q;
					res.last    = 1'b1;
					state_d     = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			count_q <= '0;
			head_q  <= '0;
			left_q  <= '0;
			cur_q   <= '0;
			hole_q  <= '0;
		end else begin
			state_q <= state_d;
			count_q <= count_d;
			head_q  <= head_d;
			left_q  <= left_d;
			cur_q   <= cur_d;
			hole_q  <= hole_d;
		end
	end

	always_ff @(posedge clk) begin
		now_q   <= now_d;
		exp_q   <= exp_d;
		owner_q <= owner_d;
		tag_q   <= tag_d;
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rdata_q <= mem[rd_addr];
		end
	end

	teq_out u_out (
		.clk          (clk),
		.arst_n       (arst_n),
		.res          (res),
		.result_valid (result_valid),
		.result_kind  (result_kind),
		.status       (status),
		.fired_owner  (fired_owner),
		.fired_tag    (fired_tag),
		.wait_ms      (wait_ms),
		.last         (last)
	);

endmodule

`default_nettype wire

>>> design/teq_out.sv
// Result register of the timer expiry queue: one-cycle strobe plus payload.
// Depends on teq_pkg for result_t.
`default_nettype none

module teq_out import teq_pkg::*; (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire result_t     res,
	output logic             result_valid,
	output logic [1:0]       result_kind,
	output logic [1:0]       status,
	output logic [15:0]      fired_owner,
	output logic [15:0]      fired_tag,
	output logic [63:0]      wait_ms,
	output logic             last
);

	logic        valid_q;
	logic [1:0]  rkind_q;
	logic [1:0]  status_q;
	logic [15:0] owner_q;
	logic [15:0] tag_q;
	logic [63:0] wait_q;
	logic        last_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else begin
			valid_q <= res.strobe;
		end
	end

	always_ff @(posedge clk) begin
		if (res.strobe) begin
			rkind_q  <= res.rkind;
			status_q <= res.status;
			owner_q  <= res.owner;
			tag_q    <= res.tag;
			wait_q   <= res.wait_ms;
			last_q   <= res.last;
		end
	end

	assign result_valid = valid_q;
	assign result_kind  = rkind_q;
	assign status       = status_q;
	assign fired_owner  = owner_q;
	assign fired_tag    = tag_q;
	assign wait_ms      = wait_q;
	assign last         = last_q;

endmodule

`default_nettype wire

>>> design/teq_checker.sv
// Port-level checks for the timer expiry queue, bound to the top level.
// Depends on teq_pkg for result and status codes.
`default_nettype none

module teq_checker import teq_pkg::*; (
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        start,
	input wire logic        busy,
	input wire logic [1:0]  kind,
	input wire logic        result_valid,
	input wire logic [1:0]  result_kind,
	input wire logic [1:0]  status,
	input wire logic        last
);

	a_fired_not_last: assert property (@(posedge clk) disable iff (!arst_n)
		(result_valid && result_kind == RK_FIRED) |-> !last)
		else $error("fired timer marked as final transaction");

	a_other_last: assert property (@(posedge clk) disable iff (!arst_n)
		(result_valid && result_kind != RK_FIRED) |-> last)
		else $error("ack or wait report not marked as final transaction");

	a_last_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(result_valid && last) |-> !busy)
		else $error("still busy while final result is shown");

	a_full_on_add: assert property (@(posedge clk) disable iff (!arst_n)
		(result_valid && status == ST_FULL) |-> result_kind == RK_ADD)
		else $error("table full status on a non-add result");

	a_unused_kind: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy && kind == K_UNUSED) |=> (!busy && !result_valid))
		else $error("unused command kind produced activity");

endmodule

bind timer_expiry_queue_top teq_checker u_teq_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.start        (start),
	.busy         (busy),
	.kind         (kind),
	.result_valid (result_valid),
	.result_kind  (result_kind),
	.status       (status),
	.last         (last)
);

`default_nettype wire

>>> tb/timer_expiry_queue_top_test.sv
// Self-checking testbench for timer_expiry_queue_top: a directed table, then random
// add, cancel and execute traffic, checked against set results or a sorted table.
// Depends on teq_pkg and the timer expiry queue RTL.
`default_nettype none

module timer_expiry_queue_top_test;
	import teq_pkg::*;

	localparam int         SLOTS        = DEF_TIMER_SLOTS;
	localparam int         RANDOM_ITEMS = 380;
	localparam int         QUIET_LIMIT  = 2000;
	localparam int         DRAIN_CYCLES = 40;

	typedef struct packed {
		logic [1:0]  rkind;
		logic [1:0]  status;
		logic [15:0] owner;
		logic [15:0] tag;
		logic [63:0] wait_ms;
		logic        last;
	} timer_result_t;

	typedef struct {
		logic [1:0]  kind;
		logic [63:0] now;
		logic [30:0] timeout;
		logic [15:0] owner;
		logic [15:0] tag;
		int          reps;
		bit          typed;
		logic [1:0]  status;
		logic [63:0] wait_ms;
	} plan_row_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        start = 1'b0;
	logic        busy;
	logic [1:0]  kind = K_ADD;
	logic [63:0] now_ms = '0;
	logic [30:0] timeout_ms = '0;
	logic [15:0] owner = '0;
	logic [15:0] timer_tag = '0;
	logic        result_valid;
	logic [1:0]  result_kind;
	logic [1:0]  status;
	logic [15:0] fired_owner;
	logic [15:0] fired_tag;
	logic [63:0] wait_ms;
	logic        last;

	logic [63:0] pend_expiry [SLOTS];
	logic [15:0] pend_owner [SLOTS];
	logic [15:0] pend_tag [SLOTS];
	int          pend_count = 0;

	timer_result_t fresh_results[$];
	timer_result_t awaited_results[$];
	plan_row_t     plan[$];
	int            mismatches = 0;
	int            quiet_cycles = 0;

	timer_expiry_queue_top u_dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.start       (start),
		.busy        (busy),
		.kind        (kind),
		.now_ms      (now_ms),
		.timeout_ms  (timeout_ms),
		.owner       (owner),
		.timer_tag   (timer_tag),
		.result_valid(result_valid),
		.result_kind (result_kind),
		.status      (status),
		.fired_owner (fired_owner),
		.fired_tag   (fired_tag),
		.wait_ms     (wait_ms),
		.last        (last)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	function automatic timer_result_t make_result(input logic [1:0] rk, input logic [1:0] st,
			input logic [15:0] o, input logic [15:0] g, input logic [63:0] w, input logic l);
		timer_result_t r;
		r.rkind   = rk;
		r.status  = st;
		r.owner   = o;
		r.tag     = g;
		r.wait_ms = w;
		r.last    = l;
		return r;
	endfunction

	task automatic drop_timer(input int pos);
		int i;
		for (i = pos; i + 1 < pend_count; i++) begin
			pend_expiry[i] = pend_expiry[i + 1];
			pend_owner[i]  = pend_owner[i + 1];
			pend_tag[i]    = pend_tag[i + 1];
		end
		pend_count--;
	endtask

	task automatic update_timer_table(input logic [1:0] k, input logic [63:0] t_now,
			input logic [30:0] t_out, input logic [15:0] o, input logic [15:0] g);
		logic [63:0] due;
		logic [63:0] remaining;
		int          pos;
		int          i;
		bit          hit;
		fresh_results.delete();
		case (k)
			K_ADD: begin
				if (pend_count >= SLOTS) begin
					fresh_results.push_back(make_result(RK_ADD, ST_FULL, '0, '0, '0, 1'b1));
				end else begin
					due = t_now + {33'd0, t_out};
					pos = 0;
					while (pos < pend_count && pend_expiry[pos] <= due)
						pos++;
					for (i = pend_count; i > pos; i--) begin
						pend_expiry[i] = pend_expiry[i - 1];
						pend_owner[i]  = pend_owner[i - 1];
						pend_tag[i]    = pend_tag[i - 1];
					end
					pend_expiry[pos] = due;
					pend_owner[pos]  = o;
					pend_tag[pos]    = g;
					pend_count++;
					fresh_results.push_back(make_result(RK_ADD, ST_OK, '0, '0, '0, 1'b1));
				end
			end
			K_CANCEL: begin
				pos = 0;
				hit = 1'b0;
				while (pos < pend_count && !hit) begin
					if (pend_owner[pos] == o && pend_tag[pos] == g)
						hit = 1'b1;
					else
						pos++;
				end
				if (hit)
					drop_timer(pos);
				fresh_results.push_back(make_result(RK_CANCEL, hit ? ST_OK : ST_NONE,
					'0, '0, '0, 1'b1));
			end
			K_EXECUTE: begin
				while (pend_count > 0 && pend_expiry[0] <= t_now) begin
					fresh_results.push_back(make_result(RK_FIRED, ST_OK, pend_owner[0],
						pend_tag[0], '0, 1'b0));
					drop_timer(0);
				end
				remaining = (pend_count > 0) ? pend_expiry[0] - t_now : 64'd0;
				fresh_results.push_back(make_result(RK_WAIT, ST_OK, '0, '0, remaining, 1'b1));
			end
			default: begin
			end
		endcase
	endtask

	task automatic issue_command(input logic [1:0] k, input logic [63:0] t_now,
			input logic [30:0] t_out, input logic [15:0] o, input logic [15:0] g,
			input bit typed, input timer_result_t typed_res);
		@(negedge clk);
		kind       = k;
		now_ms     = t_now;
		timeout_ms = t_out;
		owner      = o;
		timer_tag  = g;
		start      = 1'b1;
		do
			@(posedge clk);
		while (busy);
		update_timer_table(k, t_now, t_out, o, g);
		if (typed)
			awaited_results.push_back(typed_res);
		else
			foreach (fresh_results[i])
				awaited_results.push_back(fresh_results[i]);
	endtask

	task automatic hold_off(input int cycles);
		repeat (cycles) begin
			@(negedge clk);
			start = 1'b0;
		end
	endtask

	task automatic add_plan(input logic [1:0] k, input logic [63:0] t_now,
			input logic [30:0] t_out, input logic [15:0] o, input logic [15:0] g,
			input int reps, input bit typed, input logic [1:0] st, input logic [63:0] w);
		plan_row_t row;
		row.kind    = k;
		row.now     = t_now;
		row.timeout = t_out;
		row.owner   = o;
		row.tag     = g;
		row.reps    = reps;
		row.typed   = typed;
		row.status  = st;
		row.wait_ms = w;
		plan.push_back(row);
	endtask

	always @(posedge clk) begin
		timer_result_t got;
		timer_result_t want;
		if (arst_n && result_valid) begin
			got = make_result(result_kind, status, fired_owner, fired_tag, wait_ms, last);
			if (awaited_results.size() == 0) begin
				if (mismatches < 10)
					$display("%0t: unexpected result %0d/%0d/%h/%h/%h/%b",
						$realtime, got.rkind, got.status, got.owner, got.tag, got.wait_ms,
						got.last);
				mismatches++;
			end else begin
				want = awaited_results.pop_front();
				if (got !== want) begin
					if (mismatches < 10)
						$display("%0t: exp %0d/%0d/%h/%h/%h/%b got %0d/%0d/%h/%h/%h/%b",
							$realtime, want.rkind, want.status, want.owner, want.tag,
							want.wait_ms, want.last, got.rkind, got.status, got.owner,
							got.tag, got.wait_ms, got.last);
					mismatches++;
				end
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if ((start && !busy) || result_valid)
				quiet_cycles <= 0;
			else
				quiet_cycles <= quiet_cycles + 1;
			if (quiet_cycles >= QUIET_LIMIT) begin
				$display("Simulation FAILED");
				$finish;
			end
		end
	end

	initial begin
		timer_result_t typed_res;
		logic [1:0]    rk;
		logic [1:0]    k;
		logic [63:0]   cur_now;
		logic [63:0]   n;
		logic [30:0]   t;
		logic [15:0]   o;
		logic [15:0]   g;
		int            sent;
		int            pick;
		int            add_pct;
		int            exec_pct;
		int            idx;

		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		add_plan(K_EXECUTE, 64'd0, 31'd0, 16'h0000, 16'h0000, 1, 1'b1, ST_OK, 64'd0);
		add_plan(K_CANCEL, 64'd0, 31'd0, 16'h0000, 16'h0000, 1, 1'b1, ST_NONE, 64'd0);
		add_plan(K_ADD, '1, 31'h7FFF_FFFF, 16'hFFFF, 16'hFFFF, 1, 1'b1, ST_OK, 64'd0);
		add_plan(K_ADD, 64'd0, 31'd0, 16'h0000, 16'h0000, 1, 1'b1, ST_OK, 64'd0);
		add_plan(K_ADD, 64'd100, 31'd50, 16'h1234, 16'h0005, 1, 1'b1, ST_OK, 64'd0);
		add_plan(K_ADD, 64'd120, 31'd30, 16'h1234, 16'h0006, 1, 1'b1, ST_OK, 64'd0);
		add_plan(K_ADD, 64'd120, 31'd30, 16'h1234, 16'h0005, 1, 1'b1, ST_OK, 64'd0);
		add_plan(K_UNUSED, 64'h5A5A_A5A5_5A5A_A5A5, 31'h2AAA_AAAA, 16'h1234, 16'h0005, 1,
			1'b0, ST_OK, 64'd0);
		add_plan(K_CANCEL, 64'd0, 31'd0, 16'h1234, 16'h0007, 1, 1'b1, ST_NONE, 64'd0);
		add_plan(K_CANCEL, 64'd0, 31'd0, 16'h1234, 16'h0005, 1, 1'b1, ST_OK, 64'd0);
		add_plan(K_EXECUTE, 64'd149, 31'd0, 16'h0000, 16'h0000, 1, 1'b0, ST_OK, 64'd0);
		add_plan(K_EXECUTE, 64'd150, 31'd0, 16'h0000, 16'h0000, 1, 1'b0, ST_OK, 64'd0);
		add_plan(K_ADD, 64'd1000, 31'd7, 16'hAAAA, 16'h0000, SLOTS - 1, 1'b1, ST_OK, 64'd0);
		add_plan(K_ADD, 64'd1000, 31'd7, 16'hAAAA, 16'h0100, 1, 1'b1, ST_FULL, 64'd0);
		add_plan(K_CANCEL, 64'd0, 31'd0, 16'hAAAA, 16'h0003, 1, 1'b1, ST_OK, 64'd0);
		add_plan(K_ADD, 64'd900, 31'd0, 16'h5555, 16'h5555, 1, 1'b1, ST_OK, 64'd0);
		add_plan(K_EXECUTE, '1, 31'd0, 16'h0000, 16'h0000, 1, 1'b0, ST_OK, 64'd0);
		add_plan(K_EXECUTE, 64'd5, 31'd0, 16'h0000, 16'h0000, 1, 1'b1, ST_OK, 64'd0);
		add_plan(K_ADD, 64'hFFFF_FFFF_FFFF_FFF0, 31'h20, 16'h8001, 16'h7FFE, 1, 1'b1, ST_OK,
			64'd0);
		add_plan(K_EXECUTE, 64'h10, 31'd0, 16'h0000, 16'h0000, 1, 1'b0, ST_OK, 64'd0);

		foreach (plan[i]) begin
			case (plan[i].kind)
				K_ADD:    rk = RK_ADD;
				K_CANCEL: rk = RK_CANCEL;
				default:  rk = RK_WAIT;
			endcase
			typed_res = make_result(rk, plan[i].status, '0, '0, plan[i].wait_ms, 1'b1);
			for (int r = 0; r < plan[i].reps; r++)
				issue_command(plan[i].kind, plan[i].now, plan[i].timeout, plan[i].owner,
					plan[i].tag + 16'(r), plan[i].typed, typed_res);
		end

		// phases lean toward filling, mixing, then draining the table
		cur_now = 64'd2000;
		sent = 0;
		while (sent < RANDOM_ITEMS) begin
			case ((sent / 30) % 3)
				0:       begin add_pct = 65; exec_pct = 15; end
				1:       begin add_pct = 40; exec_pct = 30; end
				default: begin add_pct = 20; exec_pct = 50; end
			endcase
			if ($urandom_range(0, 39) == 0)
				cur_now = {$urandom, $urandom};
			pick = $urandom_range(0, 99);
			if (pick < 4)
				k = K_UNUSED;
			else if (pick < 4 + add_pct)
				k = K_ADD;
			else if (pick < 4 + add_pct + exec_pct)
				k = K_EXECUTE;
			else
				k = K_CANCEL;
			if (k == K_EXECUTE)
				cur_now = cur_now + 64'($urandom_range(0, 120));
			n = ($urandom_range(0, 19) == 0) ? {$urandom, $urandom} : cur_now;
			t = ($urandom_range(0, 9) == 0) ? 31'($urandom) : 31'($urandom_range(0, 300));
			if ($urandom_range(0, 9) < 7) begin
				o = 16'($urandom_range(0, 3));
				g = 16'($urandom_range(0, 7));
			end else begin
				o = 16'($urandom);
				g = 16'($urandom);
			end
			if (k == K_CANCEL && pend_count > 0 && $urandom_range(0, 3) != 0) begin
				idx = $urandom_range(0, pend_count - 1);
				o = pend_owner[idx];
				g = pend_tag[idx];
			end
			issue_command(k, n, t, o, g, 1'b0, typed_res);
			if (k != K_UNUSED)
				sent++;
			if (sent < RANDOM_ITEMS - 60 && ((sent / 25) % 2 == 0) && $urandom_range(0, 2) == 0)
				hold_off($urandom_range(1, 7));
		end

		@(negedge clk);
		start = 1'b0;
		while (awaited_results.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatches == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

endmodule

`default_nettype wire

>>> filelist.f
design/teq_pkg.sv
design/teq_out.sv
design/timer_expiry_queue_top.sv
design/teq_checker.sv
tb/timer_expiry_queue_top_test.sv
